FILE: rtl/tpcd_pkg.sv
// Shared types and constants of the threshold peak click detector.
`timescale 1ns / 1ps

package tpcd_pkg;

	// Field widths
	localparam int PEAK_W   = 15;
	localparam int VEL_W    = 7;
	localparam int REG_W    = 15;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int PROD_W   = PEAK_W + VEL_W;

	// Saturation limits
	localparam logic [PEAK_W-1:0] PEAK_MAX = 15'h7FFF;
	localparam logic [VEL_W-1:0]  VEL_MAX  = 7'h7F;

	// Register reset values
	localparam logic [REG_W-1:0] THRESHOLD_RST = 15'd8000;
	localparam logic [REG_W-1:0] MAX_FORCE_RST = 15'd32767;

	// Register indexes (paddr[2])
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MAX_FORCE = 1'b1;

	// Command queue between the front and the back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Divider step count (one quotient bit per step)
	localparam logic [2:0] DIV_STEPS = 3'd7;

	// One classified sample
	typedef struct packed {
		logic              done;
		logic [PEAK_W-1:0] peak;
		logic              in_click;
	} tpcd_cmd_t;

	// Back end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EMIT  = 4'b1000
	} tpcd_state_t;

endpackage

FILE: rtl/tpcd_front.sv
// Front end: accepts samples, tracks click state and peak, queues one command per sample.
`timescale 1ns / 1ps

module tpcd_front import tpcd_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic [REG_W-1:0]        threshold,
	output logic                    q_push,
	output tpcd_cmd_t               q_wdata,
	input  logic                    q_full
);

	// Compare width: sample or 16 bits, plus a sign bit
	localparam int CW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
	localparam logic signed [CW-1:0] PEAK_MAX_X = CW'(PEAK_MAX);

	logic                    clicking_q;
	logic [PEAK_W-1:0]       peak_q;
	logic signed [CW-1:0]    sample_x;
	logic signed [CW-1:0]    threshold_x;
	logic                    ge_th;
	logic                    gt_th;
	logic [PEAK_W-1:0]       clamped;
	logic                    clicking_d;
	logic [PEAK_W-1:0]       peak_d;
	logic                    done_d;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Sign-extend sample, zero-extend threshold
	assign sample_x    = {{(CW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
	assign threshold_x = {{(CW-REG_W){1'b0}}, threshold};
	assign ge_th       = sample_x >= threshold_x;
	assign gt_th       = sample_x > threshold_x;

	// Clamp sample into the 15-bit peak range
	always_comb begin
		priority if (sample_x[CW-1]) begin
			clamped = '0;
		end else if (sample_x > PEAK_MAX_X) begin
			clamped = PEAK_MAX;
		end else begin
			clamped = sample_x[PEAK_W-1:0];
		end
	end

	// Next click state
	always_comb begin
		clicking_d = clicking_q;
		peak_d     = peak_q;
		done_d     = 1'b0;
		if (clicking_q) begin
			if (ge_th) begin
				if (clamped > peak_q) begin
					peak_d = clamped;
				end
			end else begin
				done_d     = 1'b1;
				clicking_d = 1'b0;
				peak_d     = '0;
			end
		end else if (gt_th) begin
			clicking_d = 1'b1;
			peak_d     = clamped;
		end
	end

	// Command carries the peak that ended the click
	always_comb begin
		q_wdata.done     = done_d;
		q_wdata.peak     = peak_q;
		q_wdata.in_click = clicking_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clicking_q <= 1'b0;
			peak_q     <= '0;
		end else if (q_push) begin
			clicking_q <= clicking_d;
			peak_q     <= peak_d;
		end
	end

endmodule

FILE: rtl/tpcd_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module tpcd_queue import tpcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tpcd_cmd_t wdata,
	output logic      full,
	input  logic      pop,
	output tpcd_cmd_t rdata,
	output logic      empty
);

	tpcd_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/tpcd_back.sv
// Back end: computes click velocity by iterative division and holds the result register.
`timescale 1ns / 1ps

module tpcd_back import tpcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tpcd_cmd_t        q_rdata,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic [REG_W-1:0] max_force,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             click_done,
	output logic [VEL_W-1:0] velocity,
	output logic             in_click
);

	tpcd_state_t        state_q;
	logic [PROD_W-1:0]  rem_q;
	logic [PROD_W-1:0]  div_q;
	logic [VEL_W-1:0]   quo_q;
	logic [2:0]         step_q;
	logic               in_click_q;
	logic [VEL_W-1:0]   last_vel_q;
	logic               out_valid_q;
	logic               out_done_q;
	logic [VEL_W-1:0]   out_vel_q;
	logic               out_click_q;
	logic               out_free;
	logic               out_load;
	logic               ge;
	logic [PROD_W-1:0]  full_scale;

	assign out_free   = !out_valid_q || !out_stall;
	assign ge         = rem_q >= div_q;
	assign full_scale = {max_force, {VEL_W{1'b0}}};

	// A plain sample passes straight to the output; a click end starts a range check and division
	assign q_pop = (state_q == ST_IDLE) && !q_empty && (q_rdata.done || out_free);

	// Output register loads on a plain sample or at the end of a division
	assign out_load = (q_pop && !q_rdata.done) || (state_q == ST_EMIT && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_vel_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_rdata.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (rem_q >= full_scale) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 3'd1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						last_vel_q  <= quo_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath: peak*127 divided by max_force, one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q      <= {q_rdata.peak, {VEL_W{1'b0}}} - PROD_W'(q_rdata.peak);
				in_click_q <= q_rdata.in_click;
			end
			ST_CHECK: begin
				div_q  <= {1'b0, max_force, {(VEL_W-1){1'b0}}};
				quo_q  <= (rem_q >= full_scale) ? VEL_MAX : '0;
				step_q <= DIV_STEPS;
			end
			ST_DIV: begin
				if (ge) begin
					rem_q <= rem_q - div_q;
				end
				quo_q  <= {quo_q[VEL_W-2:0], ge};
				div_q  <= div_q >> 1;
				step_q <= step_q - 1'b1;
			end
			ST_EMIT: begin
				rem_q <= rem_q;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (q_pop && !q_rdata.done) begin
			out_done_q  <= 1'b0;
			out_vel_q   <= last_vel_q;
			out_click_q <= q_rdata.in_click;
		end else if (state_q == ST_EMIT && out_free) begin
			out_done_q  <= 1'b1;
			out_vel_q   <= quo_q;
			out_click_q <= in_click_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign click_done = out_done_q;
	assign velocity   = out_vel_q;
	assign in_click   = out_click_q;

endmodule

FILE: rtl/threshold_peak_click_detector.sv
// Top level of the threshold peak click detector: registers, front, queue, back.
`timescale 1ns / 1ps

// Watches a signed gyro axis sample stream for clicks: a sample above the
// threshold starts one, samples at or above it raise the peak, and the first
// sample below it ends the click with a done pulse and a velocity of
// floor(peak*127/max_force), saturated at 127. Every sample gives one result.
// A sample that does not end a click passes through the queue to the output
// register; one that ends a click goes through load, range check, seven
// restoring-division steps and output in the one-bit-per-cycle divider,
// and skips the division steps when the quotient saturates.
// A two-entry command queue lets the front keep taking samples meanwhile.
// Write threshold (0x0) and max_force (0x4) only while the block is idle.
module threshold_peak_click_detector import tpcd_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    click_done,
	output logic [VEL_W-1:0]        velocity,
	output logic                    in_click
);

	logic [REG_W-1:0] threshold_q;
	logic [REG_W-1:0] max_force_q;
	logic             cfg_wr;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	tpcd_cmd_t        q_wdata;
	tpcd_cmd_t        q_rdata;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			max_force_q <= MAX_FORCE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_THRESHOLD: threshold_q <= pwdata[REG_W-1:0];
				REG_MAX_FORCE: max_force_q <= pwdata[REG_W-1:0];
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_MAX_FORCE: prdata = DATA_W'(max_force_q);
			default:       prdata = '0;
		endcase
	end

	tpcd_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.threshold(threshold_q),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	tpcd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	tpcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.max_force (max_force_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.click_done(click_done),
		.velocity  (velocity),
		.in_click  (in_click)
	);

	// A click end always leaves the tracker idle
	a_done_not_clicking: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && click_done |-> !in_click)
		else $error("click end reported while still in a click");

	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// Back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

endmodule
